// File: rtl/core/afsa_pkg.sv
`timescale 1ns / 1ps

package afsa_pkg;

	// Default sizing of the block.
	localparam int DEFAULT_CHANNELS   = 4;
	localparam int DEFAULT_VALUE_BITS = 32;

	// Width of each reported distance and the number of reported slots.
	localparam int DISTANCE_BITS = 32;
	localparam int REPORT_SLOTS  = 4;

	// Channel reported in each output slot: a, b, c, d.
	localparam int REPORT_ORDER [REPORT_SLOTS] = '{0, 3, 2, 1};

	// Character codes recognised by the parser.
	localparam logic [7:0] CHAR_BEGIN = 8'h42;  // 'B'
	localparam logic [7:0] CHAR_END   = 8'h45;  // 'E'
	localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
	localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
	localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
	localparam logic [7:0] CHAR_TAB   = 8'h09;  // first of the control whitespace codes
	localparam logic [7:0] CHAR_CR    = 8'h0D;  // last of the control whitespace codes

	// Phase of the number conversion within one field.
	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} afsa_phase_t;

	// Commands from the parser to the channel bank for one character.
	typedef struct packed {
		logic store;  // store the finished field value in its channel
		logic take;   // end of frame: form the means and retire the newer values
	} afsa_cmd_t;

endpackage

// File: rtl/core/afsa_field_parser.sv
`timescale 1ns / 1ps

module afsa_field_parser #(
	parameter int CHANNELS   = afsa_pkg::DEFAULT_CHANNELS,
	parameter int VALUE_BITS = afsa_pkg::DEFAULT_VALUE_BITS,
	parameter int FN_W       = $clog2(CHANNELS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [7:0]                    char_in,
	output afsa_pkg::afsa_cmd_t           cmd,
	output logic [FN_W-1:0]               chan,
	output logic signed [VALUE_BITS-1:0]  value
);
	import afsa_pkg::*;

	localparam int ACC_W = VALUE_BITS + 4;

	logic                   in_frame_q, in_frame_d;
	logic [FN_W-1:0]        field_num_q, field_num_d;
	afsa_phase_t            phase_q, phase_d;
	logic                   neg_q, neg_d;
	logic [VALUE_BITS-1:0]  mag_q, mag_d;
	logic                   bad_q, bad_d;

	logic                   is_digit;
	logic                   is_space;
	logic [3:0]             digit;
	logic [ACC_W-1:0]       acc;
	logic [ACC_W-1:0]       limit;
	logic                   acc_over;
	logic                   field_good;

	// Character classes.
	assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
	assign is_space = (char_in == CHAR_SPACE) || ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));
	assign digit    = 4'(char_in - CHAR_ZERO);

	// Next magnitude: ten times the current one plus the new digit, checked against the
	// limit of the signed range for the sign read so far.
	assign acc      = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + ACC_W'(digit);
	assign limit    = (ACC_W'(1) << (VALUE_BITS - 1)) - (neg_q ? ACC_W'(0) : ACC_W'(1));
	assign acc_over = acc > limit;

	// A field is stored only when it held digits, did not overflow and has a channel.
	assign field_good = !bad_q && ((phase_q == PH_DIGITS) || (phase_q == PH_DONE))
			&& (field_num_q < FN_W'(CHANNELS));

	assign chan  = field_num_q;
	assign value = neg_q ? -$signed(mag_q) : $signed(mag_q);

	// Frame and field state update for one character.
	always_comb begin
		in_frame_d  = in_frame_q;
		field_num_d = field_num_q;
		phase_d     = phase_q;
		neg_d       = neg_q;
		mag_d       = mag_q;
		bad_d       = bad_q;
		cmd         = '0;
		priority if (char_in == CHAR_BEGIN) begin
			if (!in_frame_q) begin
				in_frame_d  = 1'b1;
				field_num_d = '0;
				phase_d     = PH_SKIP;
				neg_d       = 1'b0;
				mag_d       = '0;
				bad_d       = 1'b0;
			end
		end else if (!in_frame_q) begin
			// Characters outside a frame are ignored.
		end else if (char_in == CHAR_COMMA) begin
			cmd.store = field_good;
			if (field_num_q < FN_W'(CHANNELS)) begin
				field_num_d = FN_W'(field_num_q + 1'b1);
			end
			phase_d = PH_SKIP;
			neg_d   = 1'b0;
			mag_d   = '0;
			bad_d   = 1'b0;
		end else if (char_in == CHAR_END) begin
			cmd.store   = field_good;
			cmd.take    = 1'b1;
			in_frame_d  = 1'b0;
			field_num_d = '0;
			phase_d     = PH_SKIP;
			neg_d       = 1'b0;
			mag_d       = '0;
			bad_d       = 1'b0;
		end else begin
			unique case (phase_q)
				PH_SKIP: begin
					priority if (is_space) begin
						phase_d = PH_SKIP;
					end else if (char_in == CHAR_PLUS) begin
						phase_d = PH_SIGN;
					end else if (char_in == CHAR_MINUS) begin
						neg_d   = 1'b1;
						phase_d = PH_SIGN;
					end else if (is_digit) begin
						if (acc_over) begin
							bad_d = 1'b1;
						end else begin
							mag_d = acc[VALUE_BITS-1:0];
						end
						phase_d = PH_DIGITS;
					end else begin
						bad_d   = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_SIGN: begin
					if (is_digit) begin
						if (acc_over) begin
							bad_d = 1'b1;
						end else begin
							mag_d = acc[VALUE_BITS-1:0];
						end
						phase_d = PH_DIGITS;
					end else begin
						bad_d   = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						// Once overflowed, the field stays bad whatever follows.
						if (!bad_q) begin
							if (acc_over) begin
								bad_d = 1'b1;
							end else begin
								mag_d = acc[VALUE_BITS-1:0];
							end
						end
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = PH_SKIP;
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			field_num_q <= '0;
			phase_q     <= PH_SKIP;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			bad_q       <= 1'b0;
		end else if (step) begin
			in_frame_q  <= in_frame_d;
			field_num_q <= field_num_d;
			phase_q     <= phase_d;
			neg_q       <= neg_d;
			mag_q       <= mag_d;
			bad_q       <= bad_d;
		end
	end

endmodule

// File: rtl/core/afsa_channel_bank.sv
`timescale 1ns / 1ps

module afsa_channel_bank #(
	parameter int CHANNELS   = afsa_pkg::DEFAULT_CHANNELS,
	parameter int VALUE_BITS = afsa_pkg::DEFAULT_VALUE_BITS,
	parameter int FN_W       = $clog2(CHANNELS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  afsa_pkg::afsa_cmd_t           cmd,
	input  logic [FN_W-1:0]               chan,
	input  logic signed [VALUE_BITS-1:0]  value,
	output logic signed [VALUE_BITS-1:0]  mean [CHANNELS]
);
	import afsa_pkg::*;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		logic                          old_pres_q, new_pres_q;
		logic signed [VALUE_BITS-1:0]  old_val_q, new_val_q;
		logic                          hit;
		logic                          old_pres_e, new_pres_e;
		logic signed [VALUE_BITS-1:0]  old_val_e, new_val_e;
		logic signed [VALUE_BITS:0]    sum;
		logic signed [VALUE_BITS:0]    half;

		assign hit = cmd.store && (chan == FN_W'(i));

		// Values as they stand once the current field has been stored.
		always_comb begin
			old_pres_e = old_pres_q;
			new_pres_e = new_pres_q;
			old_val_e  = old_val_q;
			new_val_e  = new_val_q;
			if (hit) begin
				if (!old_pres_q) begin
					old_pres_e = 1'b1;
					old_val_e  = value;
				end else begin
					new_pres_e = 1'b1;
					new_val_e  = value;
				end
			end
		end

		// Mean of two values, truncated toward zero: halve, then round a negative odd sum up.
		assign sum  = {old_val_e[VALUE_BITS-1], old_val_e} + {new_val_e[VALUE_BITS-1], new_val_e};
		assign half = (sum >>> 1) + ((sum[VALUE_BITS] && sum[0]) ? (VALUE_BITS+1)'(1)
				: (VALUE_BITS+1)'(0));

		always_comb begin
			priority if (old_pres_e && new_pres_e) begin
				mean[i] = half[VALUE_BITS-1:0];
			end else if (old_pres_e) begin
				mean[i] = old_val_e;
			end else begin
				mean[i] = '0;
			end
		end

		// Presence flags.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				old_pres_q <= 1'b0;
				new_pres_q <= 1'b0;
			end else if (step) begin
				old_pres_q <= old_pres_e;
				new_pres_q <= cmd.take ? 1'b0 : new_pres_e;
			end
		end

		// Stored values; at the end of a frame the newer one moves down.
		always_ff @(posedge clk) begin
			if (step) begin
				if (cmd.take && old_pres_e && new_pres_e) begin
					old_val_q <= new_val_e;
				end else begin
					old_val_q <= old_val_e;
				end
				new_val_q <= new_val_e;
			end
		end
	end

endmodule

// File: rtl/core/ascii_frame_sensor_averager.sv
`timescale 1ns / 1ps
// Result path: the input register feeds the result register directly, so a result is presented
// once the beat carrying its 'E' is accepted and moves on from the input register.
// Throughput: one character per cycle, set by the single pass from input to result register;
// input stalls only while a result waits untaken and the staged character is an 'E' that ends a frame.
// Reset: arst_n clears the frame state and the channel presence flags at once, not the stored values.
module ascii_frame_sensor_averager #(
	parameter int CHANNELS   = afsa_pkg::DEFAULT_CHANNELS,
	parameter int VALUE_BITS = afsa_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [7:0]                              rx_char,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [afsa_pkg::DISTANCE_BITS-1:0] distance_a,
	output logic signed [afsa_pkg::DISTANCE_BITS-1:0] distance_b,
	output logic signed [afsa_pkg::DISTANCE_BITS-1:0] distance_c,
	output logic signed [afsa_pkg::DISTANCE_BITS-1:0] distance_d
);
	import afsa_pkg::*;

	localparam int FN_W = $clog2(CHANNELS + 1);

	logic                          valid_s1;
	logic [7:0]                    char_s1;
	logic                          advance;
	afsa_cmd_t                     cmd;
	logic [FN_W-1:0]               chan;
	logic signed [VALUE_BITS-1:0]  value;
	logic signed [VALUE_BITS-1:0]  mean [CHANNELS];
	logic signed [DISTANCE_BITS-1:0] slot_mean [REPORT_SLOTS];
	logic                          out_valid_q;
	logic signed [DISTANCE_BITS-1:0] dist_q [REPORT_SLOTS];

	// The staged character moves on unless it ends a frame while a result still waits.
	assign advance  = valid_s1 && (!cmd.take || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= rx_char;
		end
	end

	afsa_field_parser #(
		.CHANNELS   (CHANNELS),
		.VALUE_BITS (VALUE_BITS),
		.FN_W       (FN_W)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.char_in (char_s1),
		.cmd     (cmd),
		.chan    (chan),
		.value   (value)
	);

	afsa_channel_bank #(
		.CHANNELS   (CHANNELS),
		.VALUE_BITS (VALUE_BITS),
		.FN_W       (FN_W)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cmd    (cmd),
		.chan   (chan),
		.value  (value),
		.mean   (mean)
	);

	// Map channels onto the reported slots; a slot without a channel reports zero.
	for (genvar r = 0; r < REPORT_SLOTS; r++) begin : g_slot
		if (REPORT_ORDER[r] < CHANNELS) begin : g_used
			assign slot_mean[r] = DISTANCE_BITS'(mean[REPORT_ORDER[r]]);
		end else begin : g_unused
			assign slot_mean[r] = '0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && cmd.take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cmd.take) begin
			dist_q <= slot_mean;
		end
	end

	assign out_valid  = out_valid_q;
	assign distance_a = dist_q[0];
	assign distance_b = dist_q[1];
	assign distance_c = dist_q[2];
	assign distance_d = dist_q[3];

endmodule

// File: rtl/core/afsa_checker.sv
`timescale 1ns / 1ps

module afsa_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic [7:0]                              rx_char,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [afsa_pkg::DISTANCE_BITS-1:0] distance_a,
	input logic signed [afsa_pkg::DISTANCE_BITS-1:0] distance_b,
	input logic signed [afsa_pkg::DISTANCE_BITS-1:0] distance_c,
	input logic signed [afsa_pkg::DISTANCE_BITS-1:0] distance_d
);

	// A result beat that is not taken holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_a) && $stable(distance_b)
			&& $stable(distance_c) && $stable(distance_d))
		else $error("result beat changed while stalled");

	// Input is refused only while a result waits and is not being taken.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without a waiting result");

	// A new result follows a cycle in which the input side could move.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared while the input stage was blocked");

	// A blocked input stays blocked until the waiting result is taken.
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> !in_ready || out_ready)
		else $error("input released while the waiting result was not taken");

	// An input beat that waits keeps its character.
	a_char_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> $stable(rx_char) || !in_valid || $past(!in_valid))
		else $error("input character changed while stalled");

endmodule

bind ascii_frame_sensor_averager afsa_checker u_afsa_checker (.*);
